FILE: sv/oets_pkg.sv
// Shared constants and types for the odd-even transposition sorter.
package oets_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SORT,
    OP_EMIT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic             odd_phase;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

FILE: sv/odd_even_transposition_sort.sv
// After loading, the set sorts in R rounds, each an even and then an odd phase, R being
// the number of rounds up to and including the first round with no exchange (at most
// n/2+2 for n words); the n sorted words then leave one per cycle from cell 0.
// Throughput: one word per cycle while loading; busy is high from the last word to the
// end of emission. Results cannot be stalled. Reset (rst, synchronous) empties the set.
module odd_even_transposition_sort import oets_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [WORD_W-1:0] value,
  input  logic                     last_item,
  output logic                     strobe,
  output logic signed [WORD_W-1:0] sorted_value,
  output logic                     last_result,
  output logic                     overflowed
);

  cell_ctrl_t               ctrl;
  logic [CAPACITY-1:0]      swap;
  logic signed [WORD_W-1:0] vals [CAPACITY];

  oets_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_item   (last_item),
    .swap        (swap),
    .ctrl        (ctrl),
    .busy        (busy),
    .strobe      (strobe),
    .last_result (last_result),
    .overflowed  (overflowed)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] prev_val;
    logic signed [WORD_W-1:0] next_val;

    if (i == 0) begin : g_first
      assign prev_val = value;
    end else begin : g_mid
      assign prev_val = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign next_val = '0;
    end else begin : g_inner
      assign next_val = vals[i+1];
    end

    oets_cell u_cell (
      .clk      (clk),
      .idx      (IDX_W'(i)),
      .ctrl     (ctrl),
      .prev_val (prev_val),
      .next_val (next_val),
      .val      (vals[i]),
      .swap     (swap[i])
    );
  end

  assign sorted_value = vals[0];

endmodule

FILE: sv/oets_cell.sv
// One storage cell of the sorting chain with its compare-exchange logic.
module oets_cell import oets_pkg::*; (
  input  logic                     clk,
  input  logic [IDX_W-1:0]         idx,
  input  cell_ctrl_t               ctrl,
  input  logic signed [WORD_W-1:0] prev_val,
  input  logic signed [WORD_W-1:0] next_val,
  output logic signed [WORD_W-1:0] val,
  output logic                     swap
);

  logic signed [WORD_W-1:0] val_next;
  logic [CNT_W-1:0]         idx_ext;
  logic                     lower;
  logic                     upper;

  assign idx_ext = CNT_W'(idx);
  // lower member of a pair talks to next cell, upper member to previous
  assign lower = (idx[0] == ctrl.odd_phase) && ((idx_ext + CNT_W'(1)) < ctrl.count);
  assign upper = (idx[0] != ctrl.odd_phase) && (idx_ext != '0) && (idx_ext < ctrl.count);
  assign swap  = (ctrl.op == OP_SORT) && lower && (val > next_val);

  always_comb begin
    val_next = val;
    case (ctrl.op)
      OP_LOAD: val_next = prev_val;
      OP_EMIT: val_next = next_val;
      OP_SORT: begin
        if (lower && (val > next_val)) begin
          val_next = next_val;
        end else if (upper && (prev_val > val)) begin
          val_next = prev_val;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: sv/oets_ctrl.sv
// Sequencer for load, sort rounds and emission of the cell chain.
module oets_ctrl import oets_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                last_item,
  input  logic [CAPACITY-1:0] swap,
  output cell_ctrl_t          ctrl,
  output logic                busy,
  output logic                strobe,
  output logic                last_result,
  output logic                overflowed
);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic             swap_seen, swap_seen_next;
  logic             drop_flag, drop_flag_next;
  logic             odd_phase, odd_phase_next;
  logic             accept;
  logic             full;
  logic             any_swap;

  assign accept   = start && (state == ST_LOAD);
  assign full     = (fill_count == CNT_W'(CAPACITY));
  assign any_swap = |swap;

  assign busy        = (state != ST_LOAD);
  assign strobe      = (state == ST_EMIT);
  assign last_result = strobe && (fill_count == CNT_W'(1));
  assign overflowed  = drop_flag;

  always_comb begin
    ctrl.odd_phase = odd_phase;
    ctrl.count     = fill_count;
    case (state)
      ST_LOAD: ctrl.op = (accept && !full) ? OP_LOAD : OP_HOLD;
      ST_SORT: ctrl.op = OP_SORT;
      ST_EMIT: ctrl.op = OP_EMIT;
      default: ctrl.op = OP_HOLD;
    endcase
  end

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    swap_seen_next  = swap_seen;
    drop_flag_next  = drop_flag;
    odd_phase_next  = odd_phase;
    case (state)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            drop_flag_next = 1'b1;
          end else begin
            fill_count_next = fill_count + CNT_W'(1);
          end
          if (last_item) begin
            state_next     = ST_SORT;
            odd_phase_next = 1'b0;
            swap_seen_next = 1'b0;
          end
        end
      end
      ST_SORT: begin
        if (odd_phase) begin
          odd_phase_next = 1'b0;
          swap_seen_next = 1'b0;
          if (!(swap_seen || any_swap)) begin
            state_next = ST_EMIT;
          end
        end else begin
          odd_phase_next = 1'b1;
          swap_seen_next = swap_seen || any_swap;
        end
      end
      ST_EMIT: begin
        fill_count_next = fill_count - CNT_W'(1);
        if (fill_count == CNT_W'(1)) begin
          state_next     = ST_LOAD;
          drop_flag_next = 1'b0;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      fill_count <= '0;
      swap_seen  <= 1'b0;
      drop_flag  <= 1'b0;
      odd_phase  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      swap_seen  <= swap_seen_next;
      drop_flag  <= drop_flag_next;
      odd_phase  <= odd_phase_next;
    end
  end

endmodule

FILE: sv/oets_checker.sv
// Port-level checks for the sorter, bound to the top level.
module oets_checker import oets_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     busy,
  input logic                     strobe,
  input logic signed [WORD_W-1:0] sorted_value,
  input logic                     last_result,
  input logic                     overflowed
);

  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_result |=> strobe)
    else $error("emission burst broken");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("word emitted while idle");

  a_done: assert property (@(posedge clk) disable iff (rst)
    strobe && last_result |=> !busy && !strobe)
    else $error("sorter not idle after final word");

  a_order: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_result |=> sorted_value >= $past(sorted_value))
    else $error("words not ascending");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_result |=> overflowed == $past(overflowed))
    else $error("overflow flag changed within a set");

endmodule

bind odd_even_transposition_sort oets_checker u_oets_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .strobe       (strobe),
  .sorted_value (sorted_value),
  .last_result  (last_result),
  .overflowed   (overflowed)
);
